>>> hw/rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants shared by the linear-probe hash table modules.
// ----------------------------------------------------------------------------
package lpht_pkg;

   // Key mixer: xor-shift, multiply, xor-shift
   localparam logic [63:0] MIX_MUL   = 64'hff51afd7ed558ccd;
   localparam int          MIX_SHIFT = 33;
   localparam int          CHUNK_W   = 16;

   localparam int ENTRY_COUNT_W = 13;

   localparam logic [3:0] CAP_LOG2_MIN   = 4'd4;
   localparam logic [3:0] CAP_LOG2_RESET = 4'd12;

   // Operation codes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_FIND   = 2'd2;

   // Result status codes
   localparam logic [2:0] STAT_STORED    = 3'd0;
   localparam logic [2:0] STAT_DUP       = 3'd1;
   localparam logic [2:0] STAT_ZERO_LEN  = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_HIT       = 3'd4;
   localparam logic [2:0] STAT_MISS      = 3'd5;
   localparam logic [2:0] STAT_CLEARED   = 3'd6;
   localparam logic [2:0] STAT_NOT_READY = 3'd7;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key;
      logic [31:0] text_offset;
      logic [15:0] text_length;
   } req_type;

   typedef struct packed {
      logic [2:0]               status;
      logic [31:0]              found_offset;
      logic [15:0]              found_length;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key;
      logic [31:0] text_offset;
      logic [15:0] text_length;
   } slot_type;

   // Controller to datapath
   typedef struct packed {
      logic       item_load;
      logic       sweep_start;
      logic       sweep_step;
      logic       clear_commit;
      logic       mul_start;
      logic       mul_step;
      logic       load_home;
      logic       probe_next;
      logic       slot_write;
      logic       count_inc;
      logic       res_set;
      logic       res_hit;
      logic [2:0] res_code;
      logic       rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       len_zero;
      logic       table_ready;
      logic       sweep_last;
      logic       mul_done;
      logic       slot_empty;
      logic       key_match;
      logic       probe_last;
      logic       rsp_free;
   } sts_type;

endpackage

>>> hw/rtl/lpht_dp.sv
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: item and config registers, sequential key mixer, slot memory,
// probe index and count, result staging and output register.
// ----------------------------------------------------------------------------
module lpht_dp
   import lpht_pkg::*;
#(
   parameter int MAX_SLOTS_LOG2 = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       csr_valid,
   input  logic [3:0] csr_data,
   input  cmd_type    cmd,
   output sts_type    sts,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   localparam int SLOTS  = 1 << MAX_SLOTS_LOG2;
   localparam int IW     = MAX_SLOTS_LOG2;
   localparam int CW     = MAX_SLOTS_LOG2 + 1;
   localparam int AW     = $clog2(MAX_SLOTS_LOG2 + 1);
   localparam int EW     = (CW > ENTRY_COUNT_W) ? CW : ENTRY_COUNT_W;
   localparam int NCHUNK = 64 / CHUNK_W;
   localparam int MCW    = $clog2(NCHUNK + 1);
   localparam int SW     = $clog2(NCHUNK);
   localparam int PW     = CHUNK_W + 64;

   req_type          item_ff;
   logic [3:0]       cap_log2_ff, cap_log2_in;
   logic [IW-1:0]    mask_ff, mask_in;
   logic             table_ready_ff, table_ready_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [IW-1:0]    probe_cnt_ff, probe_cnt_in;
   logic [MCW-1:0]   mul_cnt_ff, mul_cnt_in;
   logic             prod_vld_ff, prod_vld_in;
   logic [SW-1:0]    prod_sel_ff;
   logic [63:0]      prod_ff;
   logic [63:0]      acc_ff, acc_in;
   slot_type         mem [SLOTS];
   slot_type         rdata_ff;
   slot_type         wdata;
   logic             mem_we;
   logic [2:0]       res_status_ff;
   logic [31:0]      res_off_ff;
   logic [15:0]      res_len_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   logic [63:0]      mix_x;
   logic [CHUNK_W-1:0] chunk;
   logic [PW-1:0]    mul_full;
   logic [63:0]      prod_shifted;
   logic [63:0]      hash;
   logic [IW-1:0]    home;
   logic [AW-1:0]    act_log2;
   logic [EW-1:0]    count_ext;

   // Key mixer, one 16-bit chunk of the pre-mixed key per cycle
   assign mix_x        = item_ff.key ^ (item_ff.key >> MIX_SHIFT);
   assign chunk        = mix_x[CHUNK_W * int'(mul_cnt_ff[SW-1:0]) +: CHUNK_W];
   assign mul_full     = PW'(chunk) * PW'(MIX_MUL);
   assign prod_shifted = prod_ff << (int'(prod_sel_ff) * CHUNK_W);
   assign hash         = acc_ff ^ (acc_ff >> MIX_SHIFT);
   assign home         = hash[IW-1:0] & mask_ff;

   // Clip the requested capacity into the supported range
   always_comb begin
      priority if (cap_log2_ff < CAP_LOG2_MIN) begin
         act_log2 = AW'(CAP_LOG2_MIN);
      end else if (int'(cap_log2_ff) > MAX_SLOTS_LOG2) begin
         act_log2 = AW'(MAX_SLOTS_LOG2);
      end else begin
         act_log2 = AW'(cap_log2_ff);
      end
   end

   always_comb begin
      cap_log2_in    = csr_valid ? csr_data : cap_log2_ff;
      mask_in        = mask_ff;
      table_ready_in = table_ready_ff;
      count_in       = count_ff;
      if (cmd.clear_commit) begin
         for (int b = 0; b < IW; b++) begin
            mask_in[b] = (b < int'(act_log2));
         end
         table_ready_in = 1'b1;
         count_in       = '0;
      end else if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      probe_cnt_in = probe_cnt_ff;
      priority if (cmd.sweep_start) begin
         idx_in = '0;
      end else if (cmd.sweep_step) begin
         idx_in = idx_ff + IW'(1);
      end else if (cmd.load_home) begin
         idx_in       = home;
         probe_cnt_in = '0;
      end else if (cmd.probe_next) begin
         idx_in       = (idx_ff + IW'(1)) & mask_ff;
         probe_cnt_in = probe_cnt_ff + IW'(1);
      end
   end

   always_comb begin
      mul_cnt_in  = mul_cnt_ff;
      prod_vld_in = prod_vld_ff;
      acc_in      = acc_ff;
      if (cmd.mul_start) begin
         mul_cnt_in  = '0;
         prod_vld_in = 1'b0;
         acc_in      = '0;
      end else if (cmd.mul_step) begin
         prod_vld_in = (int'(mul_cnt_ff) < NCHUNK);
         if (int'(mul_cnt_ff) < NCHUNK) begin
            mul_cnt_in = mul_cnt_ff + MCW'(1);
         end
         if (prod_vld_ff) begin
            acc_in = acc_ff + prod_shifted;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_log2_ff    <= CAP_LOG2_RESET;
         mask_ff        <= '0;
         table_ready_ff <= 1'b0;
         count_ff       <= '0;
         mul_cnt_ff     <= '0;
         prod_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cap_log2_ff    <= cap_log2_in;
         mask_ff        <= mask_in;
         table_ready_ff <= table_ready_in;
         count_ff       <= count_in;
         mul_cnt_ff     <= mul_cnt_in;
         prod_vld_ff    <= prod_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         item_ff <= req_data;
      end
      idx_ff       <= idx_in;
      probe_cnt_ff <= probe_cnt_in;
      acc_ff       <= acc_in;
      if (cmd.mul_step) begin
         prod_ff     <= mul_full[63:0];
         prod_sel_ff <= mul_cnt_ff[SW-1:0];
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_code;
         res_off_ff    <= cmd.res_hit ? rdata_ff.text_offset : '0;
         res_len_ff    <= cmd.res_hit ? rdata_ff.text_length : '0;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff.status       <= res_status_ff;
         rsp_data_ff.found_offset <= res_off_ff;
         rsp_data_ff.found_length <= res_len_ff;
         rsp_data_ff.entry_count  <= count_ext[ENTRY_COUNT_W-1:0];
      end
   end

   // Slot memory: one write port and one registered read port on idx_ff
   assign mem_we            = cmd.slot_write | cmd.sweep_step;
   assign wdata.key         = item_ff.key;
   assign wdata.text_offset = item_ff.text_offset;
   assign wdata.text_length = cmd.sweep_step ? 16'd0 : item_ff.text_length;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[idx_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[idx_ff];
   end

   assign count_ext = EW'(count_ff);

   assign sts.op          = item_ff.op;
   assign sts.len_zero    = (item_ff.text_length == 16'd0);
   assign sts.table_ready = table_ready_ff;
   assign sts.sweep_last  = &idx_ff;
   assign sts.mul_done    = (int'(mul_cnt_ff) == NCHUNK) && !prod_vld_ff;
   assign sts.slot_empty  = (rdata_ff.text_length == 16'd0);
   assign sts.key_match   = (rdata_ff.key == item_ff.key);
   assign sts.probe_last  = (probe_cnt_ff == mask_ff);
   assign sts.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_write_into_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.slot_write |-> (rdata_ff.text_length == 16'd0) &&
                         (item_ff.text_length != 16'd0))
      else $error("insert overwrites an occupied slot or stores zero length");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      table_ready_ff |-> (count_ff <= (CW'(mask_ff) + CW'(1))))
      else $error("entry count exceeds active slot count");

   a_insert_needs_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> table_ready_ff && !cmd.clear_commit)
      else $error("entry counted before the table was cleared");

endmodule

>>> hw/rtl/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: sequences decode, clear sweep, key mixing, probing and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module lpht_ctrl
   import lpht_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      CS_IDLE   = 7'b0000001,
      CS_DECODE = 7'b0000010,
      CS_SWEEP  = 7'b0000100,
      CS_MIX    = 7'b0001000,
      CS_READ   = 7'b0010000,
      CS_CHECK  = 7'b0100000,
      CS_FINISH = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           is_insert;

   assign is_insert = (sts.op == OP_INSERT);

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready     = 1'b1;
            cmd.item_load = req_valid;
            if (req_valid) begin
               state_in = CS_DECODE;
            end
         end
         CS_DECODE: begin
            priority if (sts.op == OP_CLEAR) begin
               cmd.sweep_start = 1'b1;
               state_in        = CS_SWEEP;
            end else if ((sts.op == OP_INSERT || sts.op == OP_FIND) &&
                         sts.table_ready) begin
               if (is_insert && sts.len_zero) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = STAT_ZERO_LEN;
                  state_in     = CS_FINISH;
               end else begin
                  cmd.mul_start = 1'b1;
                  state_in      = CS_MIX;
               end
            end else begin
               cmd.res_set  = 1'b1;
               cmd.res_code = STAT_NOT_READY;
               state_in     = CS_FINISH;
            end
         end
         CS_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               cmd.clear_commit = 1'b1;
               cmd.res_set      = 1'b1;
               cmd.res_code     = STAT_CLEARED;
               state_in         = CS_FINISH;
            end
         end
         CS_MIX: begin
            cmd.mul_step = 1'b1;
            if (sts.mul_done) begin
               cmd.load_home = 1'b1;
               state_in      = CS_READ;
            end
         end
         CS_READ: begin
            state_in = CS_CHECK;
         end
         CS_CHECK: begin
            // empty slot ends the chain before any key compare
            priority if (sts.slot_empty) begin
               cmd.res_set = 1'b1;
               if (is_insert) begin
                  cmd.slot_write = 1'b1;
                  cmd.count_inc  = 1'b1;
                  cmd.res_code   = STAT_STORED;
               end else begin
                  cmd.res_code = STAT_MISS;
               end
               state_in = CS_FINISH;
            end else if (sts.key_match) begin
               cmd.res_set  = 1'b1;
               cmd.res_hit  = !is_insert;
               cmd.res_code = is_insert ? STAT_DUP : STAT_HIT;
               state_in     = CS_FINISH;
            end else if (sts.probe_last) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = is_insert ? STAT_FULL : STAT_MISS;
               state_in     = CS_FINISH;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = CS_READ;
            end
         end
         CS_FINISH: begin
            // hold until the output register can take the item
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("result loaded while previous one still pending");

   a_hit_needs_match: assert property (@(posedge clock) disable iff (reset)
      cmd.res_hit |-> sts.key_match && !sts.slot_empty && !is_insert)
      else $error("hit reported without a matching occupied slot");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state is not one-hot");

endmodule

>>> hw/rtl/linear_probe_hash_table_top.sv
// Insert/find: after accept, decode and key mixing, then one memory read and
//   one compare for the home slot and for each further slot probed.
// Clear: the sweep writes all 2**MAX_SLOTS_LOG2 slots, one slot written per cycle.
// One item in flight; the next item is taken only after the result has been
//   loaded into the output register.
// Synchronous reset: table not ready, count zero, capacity_log2 = 12.
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing hash table with 64-bit keys and linear probing.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top
   import lpht_pkg::*;
#(
   parameter int MAX_SLOTS_LOG2 = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpht_dp #(
      .MAX_SLOTS_LOG2 (MAX_SLOTS_LOG2)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> dv/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Watches the request, result and capacity ports of the hash table, keeps
// its own copy of the slot store, predicts every result and compares it
// field by field against what comes out of the block.
// ----------------------------------------------------------------------------
module lpht_checker
   import lpht_pkg::*;
#(
   parameter int MAX_SLOTS_LOG2 = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [3:0] csr_data,
   output int         mismatch_count,
   output int         outstanding,
   output int         checked_count,
   output logic [7:0] status_seen
);

   localparam int SLOT_COUNT       = 1 << MAX_SLOTS_LOG2;
   localparam int MISMATCH_REPORTS = 10;

   bit [63:0]              slot_key    [SLOT_COUNT];
   bit [31:0]              slot_offset [SLOT_COUNT];
   bit [15:0]              slot_length [SLOT_COUNT];
   bit [ENTRY_COUNT_W-1:0] occupied;
   bit                     table_ready;
   bit [3:0]               capacity_log2_reg;
   int unsigned            active_log2;

   rsp_type    expected_results [$];
   int         errors  = 0;
   int         checked = 0;
   logic [7:0] seen    = '0;

   // Apply one item to the shadow table and return the result it should give.
   function automatic rsp_type apply_table_op(input req_type item);
      rsp_type     res;
      bit [63:0]   mixed;
      int unsigned span;
      int unsigned slot;
      bit          hit;
      bit          vacant;
      res        = '0;
      res.status = STAT_NOT_READY;
      hit        = 1'b0;
      vacant     = 1'b0;
      if (item.op == OP_CLEAR) begin
         foreach (slot_length[i]) slot_length[i] = '0;
         occupied    = '0;
         table_ready = 1'b1;
         // the capacity register only takes effect here, clipped to the legal range
         if (capacity_log2_reg < CAP_LOG2_MIN) active_log2 = int'(CAP_LOG2_MIN);
         else if (int'(capacity_log2_reg) > MAX_SLOTS_LOG2) active_log2 = MAX_SLOTS_LOG2;
         else active_log2 = int'(capacity_log2_reg);
         res.status = STAT_CLEARED;
      end else if ((item.op == OP_INSERT || item.op == OP_FIND) && table_ready) begin
         if (item.op == OP_INSERT && item.text_length == '0) begin
            res.status = STAT_ZERO_LEN;
         end else begin
            span  = 1 << active_log2;
            mixed = item.key ^ (item.key >> MIX_SHIFT);
            mixed = mixed * MIX_MUL;
            mixed = mixed ^ (mixed >> MIX_SHIFT);
            slot  = mixed[31:0] & (span - 1);
            // probe at most one full round, wrapping inside the active slots
            for (int unsigned n = 0; n < span; n++) begin
               if (slot_length[slot] == '0) begin
                  vacant = 1'b1;
                  break;
               end
               if (slot_key[slot] == item.key) begin
                  hit = 1'b1;
                  break;
               end
               slot = (slot + 1) & (span - 1);
            end
            if (item.op == OP_INSERT) begin
               if (hit) begin
                  res.status = STAT_DUP;
               end else if (vacant) begin
                  slot_key[slot]    = item.key;
                  slot_offset[slot] = item.text_offset;
                  slot_length[slot] = item.text_length;
                  occupied++;
                  res.status = STAT_STORED;
               end else begin
                  res.status = STAT_FULL;
               end
            end else if (hit) begin
               res.status       = STAT_HIT;
               res.found_offset = slot_offset[slot];
               res.found_length = slot_length[slot];
            end else begin
               res.status = STAT_MISS;
            end
         end
      end
      res.entry_count = occupied;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (slot_length[i]) slot_length[i] = '0;
         occupied          = '0;
         table_ready       = 1'b0;
         capacity_log2_reg = CAP_LOG2_RESET;
         active_log2       = (int'(CAP_LOG2_RESET) > MAX_SLOTS_LOG2) ?
                             MAX_SLOTS_LOG2 : int'(CAP_LOG2_RESET);
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) capacity_log2_reg = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= MISMATCH_REPORTS)
                  $display("unexpected result: status %0d offset %h length %h count %0d",
                           rsp_data.status, rsp_data.found_offset, rsp_data.found_length,
                           rsp_data.entry_count);
            end else begin
               want = expected_results.pop_front();
               checked++;
               seen[want.status] = 1'b1;
               if (rsp_data.status !== want.status ||
                   rsp_data.found_offset !== want.found_offset ||
                   rsp_data.found_length !== want.found_length ||
                   rsp_data.entry_count !== want.entry_count) begin
                  errors++;
                  if (errors <= MISMATCH_REPORTS)
                     $display({"result %0d mismatch: expected status %0d offset %h ",
                               "length %h count %0d, got status %0d offset %h ",
                               "length %h count %0d"},
                              checked, want.status, want.found_offset, want.found_length,
                              want.entry_count, rsp_data.status, rsp_data.found_offset,
                              rsp_data.found_length, rsp_data.entry_count);
               end
            end
         end
         // a result never belongs to the item taken at the same edge
         if (req_valid && req_ready) expected_results.push_back(apply_table_op(req_data));
      end
      mismatch_count <= errors;
      outstanding    <= expected_results.size();
      checked_count  <= checked;
      status_seen    <= seen;
   end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the linear-probe hash table through directed corner cases, then
// through phases of random inserts and finds at changing capacities, with
// random stalls on both sides; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
   import lpht_pkg::*;

   localparam int         MAX_LOG2         = 12;
   localparam logic [1:0] OP_UNUSED        = 2'd3;
   localparam int         RANDOM_ITEMS     = 1800;
   localparam int         QUIET_TAIL_ITEMS = 150;
   localparam int         LONG_HOLD_AT     = 400;
   localparam int         LONG_HOLD_CYCLES = 400;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [3:0] csr_data  = '0;

   int         mismatch_count;
   int         outstanding;
   int         checked_count;
   logic [7:0] status_seen;

   int         items_sent       = 0;
   int         phase_count      = 0;
   int         csr_writes       = 0;
   bit         quiet_tail       = 1'b0;
   bit         req_noisy        = 1'b1;
   bit         long_hold_done   = 1'b0;
   int         table_log2       = int'(CAP_LOG2_RESET);
   logic [3:0] capacity_written = CAP_LOG2_RESET;
   bit [63:0]  key_pool [$];

   always #1 clock = ~clock;

   linear_probe_hash_table_top #(
      .MAX_SLOTS_LOG2(MAX_LOG2)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   lpht_checker #(
      .MAX_SLOTS_LOG2(MAX_LOG2)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count),
      .status_seen    (status_seen)
   );

   function automatic bit [63:0] random_key();
      return {$urandom, $urandom};
   endfunction

   function automatic bit [63:0] pick_key(input int pool_percent);
      if (key_pool.size() != 0 && $urandom_range(0, 99) < pool_percent)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      return random_key();
   endfunction

   task automatic offer(input logic [1:0] op, input bit [63:0] key,
                        input bit [31:0] offset, input bit [15:0] length);
      req_type item;
      item.op          = op;
      item.key         = key;
      item.text_offset = offset;
      item.text_length = length;
      if (!quiet_tail && req_noisy && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // hold the sender until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_capacity(input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      capacity_written = value;
      csr_writes++;
   endtask

   task automatic send_clear();
      offer(OP_CLEAR, random_key(), $urandom, 16'($urandom));
      if (capacity_written < CAP_LOG2_MIN) table_log2 = int'(CAP_LOG2_MIN);
      else if (int'(capacity_written) > MAX_LOG2) table_log2 = MAX_LOG2;
      else table_log2 = int'(capacity_written);
      key_pool.delete();
   endtask

   task automatic send_insert(input bit [63:0] key, input bit [15:0] length);
      offer(OP_INSERT, key, $urandom, length);
      if (length != '0) key_pool.push_back(key);
   endtask

   // result side: random stall bursts, calm stretches, one long hold-off
   initial begin
      int stretch;
      bit calm;
      stretch = 0;
      calm    = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && items_sent >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!quiet_tail && !calm && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
         if (stretch == 0) begin
            calm    = ($urandom_range(0, 3) == 0);
            stretch = $urandom_range(50, 300);
         end else begin
            stretch--;
         end
      end
   end

   initial begin
      int         first_random;
      int         phase_len;
      int         slots;
      int         pick;
      logic [3:0] capacity;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // table not ready before the first clear
      offer(OP_INSERT, '1, '1, '1);
      offer(OP_FIND, '0, '0, '0);
      offer(OP_INSERT, random_key(), $urandom, '0);
      offer(OP_UNUSED, random_key(), $urandom, 16'hffff);

      // capacity from reset, basic insert and find behavior
      send_clear();
      send_insert('0, 16'd1);
      offer(OP_INSERT, '1, '1, '1);
      offer(OP_INSERT, '0, 32'h1234_5678, 16'h00ff);
      offer(OP_INSERT, random_key(), $urandom, '0);
      offer(OP_FIND, '0, $urandom, '0);
      offer(OP_FIND, '1, '0, '0);
      offer(OP_FIND, random_key(), '0, '0);
      offer(OP_UNUSED, '1, '1, '1);

      // a capacity write waits for the next clear; below minimum clips up
      drain();
      write_capacity(4'd0);
      offer(OP_FIND, '1, '0, '0);
      send_clear();
      offer(OP_FIND, '1, '0, '0);

      // fill the smallest table, then run into the full case
      repeat (1 << CAP_LOG2_MIN) send_insert(random_key(), 16'($urandom_range(1, 65535)));
      offer(OP_INSERT, random_key(), $urandom, 16'd7);
      offer(OP_FIND, random_key(), '0, '0);
      offer(OP_INSERT, key_pool[0], $urandom, 16'd9);

      // above maximum clips down, again only after the clear
      drain();
      write_capacity(4'hf);
      offer(OP_INSERT, random_key(), $urandom, 16'd3);
      send_clear();

      first_random = items_sent;
      while (items_sent - first_random < RANDOM_ITEMS) begin
         drain();
         phase_count++;
         req_noisy = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) capacity = 4'd4;
            else if (pick < 55) capacity = 4'd5;
            else if (pick < 70) capacity = 4'd6;
            else if (pick < 78) capacity = 4'($urandom_range(0, 3));
            else if (pick < 86) capacity = 4'($urandom_range(7, 11));
            else if (pick < 93) capacity = 4'd12;
            else capacity = 4'($urandom_range(13, 15));
            write_capacity(capacity);
         end
         if ($urandom_range(0, 5) != 0) send_clear();
         slots     = 1 << table_log2;
         phase_len = (slots <= 64) ? $urandom_range(slots, 2 * slots + 8)
                                   : $urandom_range(20, 60);
         for (int n = 0; n < phase_len; n++) begin
            if (items_sent - first_random >= RANDOM_ITEMS - QUIET_TAIL_ITEMS)
               quiet_tail = 1'b1;
            if (!quiet_tail && $urandom_range(0, 49) == 0) drain();
            pick = $urandom_range(0, 99);
            if (pick < 50)
               send_insert(pick_key(25),
                           ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)));
            else if (pick < 92)
               offer(OP_FIND, pick_key(65), $urandom, 16'($urandom));
            else if (pick < 99)
               offer(OP_UNUSED, random_key(), $urandom, 16'($urandom));
            else
               send_clear();
         end
      end

      drain();
      repeat (64) @(posedge clock);
      $display("Run covered %0d items over %0d table phases and %0d capacity writes",
               items_sent, phase_count, csr_writes);
      $display("%0d results checked; status codes seen (7..0): %b", checked_count, status_seen);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_dp.sv
hw/rtl/lpht_ctrl.sv
hw/rtl/linear_probe_hash_table_top.sv
dv/lpht_checker.sv
dv/tb.sv
